FILE: rtl/core/dual_mode_pid_with_integral_clamp_macros.svh
// Assertion macros shared by the dual-mode PID RTL.
// Included by the modules that check their own pipeline and state logic.
`ifndef DUAL_MODE_PID_WITH_INTEGRAL_CLAMP_MACROS_SVH
`define DUAL_MODE_PID_WITH_INTEGRAL_CLAMP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DMPID_ASSERT_IMPLY(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("dmpid: check failed");
// next-cycle implication
`define DMPID_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("dmpid: check failed");
`else
`define DMPID_ASSERT_IMPLY(name, clk, rst, pre, post)
`define DMPID_ASSERT_NEXT(name, clk, rst, pre, post)
`endif

`endif

FILE: rtl/core/dmpid_pkg.sv
// Types, widths and register codes for the dual-mode PID controller.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps

package dmpid_pkg;

   localparam int VALUE_WIDTH        = 24;
   localparam int GAIN_FRACTION_BITS = 8;
   localparam int GAIN_WIDTH         = 16;
   localparam int DRIVE_LIMIT_WIDTH  = 13;
   localparam int TURN_LIMIT_WIDTH   = 9;
   localparam int DRIVE_INT_WIDTH    = 14;
   localparam int TURN_INT_WIDTH     = 10;
   localparam int ERR_WIDTH          = VALUE_WIDTH + 1;
   localparam int DIFF_WIDTH         = ERR_WIDTH + 1;
   localparam int ACC_WIDTH          = ERR_WIDTH + 1;
   localparam int P_WIDTH            = GAIN_WIDTH + ERR_WIDTH;
   localparam int I_WIDTH            = GAIN_WIDTH + DRIVE_INT_WIDTH;
   localparam int D_WIDTH            = GAIN_WIDTH + DIFF_WIDTH;
   localparam int SUM_WIDTH          = D_WIDTH + 2;
   localparam int SHIFT_WIDTH        = SUM_WIDTH - GAIN_FRACTION_BITS;
   localparam int POWER_WIDTH        = 8;
   localparam int POWER_LIMIT        = 100;

   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [GAIN_WIDTH-1:0]        RESET_KP          = 16'd256;
   localparam logic [GAIN_WIDTH-1:0]        RESET_KI          = 16'd0;
   localparam logic [GAIN_WIDTH-1:0]        RESET_KD          = 16'd0;
   localparam logic [DRIVE_LIMIT_WIDTH-1:0] RESET_DRIVE_LIMIT = 13'd4300;
   localparam logic [TURN_LIMIT_WIDTH-1:0]  RESET_TURN_LIMIT  = 9'd360;

   typedef enum logic [2:0] {
      REG_DRIVE_KP    = 3'd0,
      REG_DRIVE_KI    = 3'd1,
      REG_DRIVE_KD    = 3'd2,
      REG_TURN_KP     = 3'd3,
      REG_TURN_KI     = 3'd4,
      REG_TURN_KD     = 3'd5,
      REG_DRIVE_LIMIT = 3'd6,
      REG_TURN_LIMIT  = 3'd7
   } reg_index_type;

   typedef enum logic {
      CMD_DRIVE = 1'b0,
      CMD_TURN  = 1'b1
   } cmd_type;

   typedef struct packed {
      logic                          cmd;
      logic signed [VALUE_WIDTH-1:0] target;
      logic signed [VALUE_WIDTH-1:0] measured_value;
   } req_type;

   typedef struct packed {
      logic signed [POWER_WIDTH-1:0] drive_power;
      logic                          output_saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [GAIN_WIDTH-1:0] kp;
      logic signed [GAIN_WIDTH-1:0] ki;
      logic signed [GAIN_WIDTH-1:0] kd;
   } gains_type;

   typedef struct packed {
      gains_type                      drive;
      gains_type                      turn;
      logic [DRIVE_LIMIT_WIDTH-1:0]   drive_limit;
      logic [TURN_LIMIT_WIDTH-1:0]    turn_limit;
   } cfg_type;

   // error stage -> multiply stage
   typedef struct packed {
      gains_type                         gains;
      logic signed [ERR_WIDTH-1:0]       err;
      logic signed [DRIVE_INT_WIDTH-1:0] acc;
      logic signed [DIFF_WIDTH-1:0]      diff;
   } err_stage_type;

   // multiply stage -> output stage
   typedef struct packed {
      logic signed [P_WIDTH-1:0] p_term;
      logic signed [I_WIDTH-1:0] i_term;
      logic signed [D_WIDTH-1:0] d_term;
   } prod_stage_type;

endpackage

FILE: rtl/core/dmpid_csr.sv
// APB-style register file holding the gains and windup limits.
// Depends on dmpid_pkg.
`timescale 1ns / 1ps

module dmpid_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [dmpid_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [dmpid_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [dmpid_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready,
   output dmpid_pkg::cfg_type                  cfg
);

   dmpid_pkg::cfg_type       cfg_ff, cfg_in;
   dmpid_pkg::reg_index_type reg_index;
   logic                     wr_en;

   assign reg_index = dmpid_pkg::reg_index_type'(paddr[4:2]);
   assign wr_en     = psel & penable & pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            dmpid_pkg::REG_DRIVE_KP:    cfg_in.drive.kp = pwdata[dmpid_pkg::GAIN_WIDTH-1:0];
            dmpid_pkg::REG_DRIVE_KI:    cfg_in.drive.ki = pwdata[dmpid_pkg::GAIN_WIDTH-1:0];
            dmpid_pkg::REG_DRIVE_KD:    cfg_in.drive.kd = pwdata[dmpid_pkg::GAIN_WIDTH-1:0];
            dmpid_pkg::REG_TURN_KP:     cfg_in.turn.kp  = pwdata[dmpid_pkg::GAIN_WIDTH-1:0];
            dmpid_pkg::REG_TURN_KI:     cfg_in.turn.ki  = pwdata[dmpid_pkg::GAIN_WIDTH-1:0];
            dmpid_pkg::REG_TURN_KD:     cfg_in.turn.kd  = pwdata[dmpid_pkg::GAIN_WIDTH-1:0];
            dmpid_pkg::REG_DRIVE_LIMIT: begin
               cfg_in.drive_limit = pwdata[dmpid_pkg::DRIVE_LIMIT_WIDTH-1:0];
            end
            dmpid_pkg::REG_TURN_LIMIT: begin
               cfg_in.turn_limit = pwdata[dmpid_pkg::TURN_LIMIT_WIDTH-1:0];
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drive.kp    <= dmpid_pkg::RESET_KP;
         cfg_ff.drive.ki    <= dmpid_pkg::RESET_KI;
         cfg_ff.drive.kd    <= dmpid_pkg::RESET_KD;
         cfg_ff.turn.kp     <= dmpid_pkg::RESET_KP;
         cfg_ff.turn.ki     <= dmpid_pkg::RESET_KI;
         cfg_ff.turn.kd     <= dmpid_pkg::RESET_KD;
         cfg_ff.drive_limit <= dmpid_pkg::RESET_DRIVE_LIMIT;
         cfg_ff.turn_limit  <= dmpid_pkg::RESET_TURN_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_index)
         dmpid_pkg::REG_DRIVE_KP:    prdata = dmpid_pkg::CSR_DATA_WIDTH'(cfg_ff.drive.kp);
         dmpid_pkg::REG_DRIVE_KI:    prdata = dmpid_pkg::CSR_DATA_WIDTH'(cfg_ff.drive.ki);
         dmpid_pkg::REG_DRIVE_KD:    prdata = dmpid_pkg::CSR_DATA_WIDTH'(cfg_ff.drive.kd);
         dmpid_pkg::REG_TURN_KP:     prdata = dmpid_pkg::CSR_DATA_WIDTH'(cfg_ff.turn.kp);
         dmpid_pkg::REG_TURN_KI:     prdata = dmpid_pkg::CSR_DATA_WIDTH'(cfg_ff.turn.ki);
         dmpid_pkg::REG_TURN_KD:     prdata = dmpid_pkg::CSR_DATA_WIDTH'(cfg_ff.turn.kd);
         dmpid_pkg::REG_DRIVE_LIMIT: prdata = dmpid_pkg::CSR_DATA_WIDTH'(cfg_ff.drive_limit);
         dmpid_pkg::REG_TURN_LIMIT:  prdata = dmpid_pkg::CSR_DATA_WIDTH'(cfg_ff.turn_limit);
         default:                    prdata = '0;
      endcase
   end

endmodule

FILE: rtl/core/dmpid_err.sv
// Input register, error, clamped integral and per-mode loop state.
// Depends on dmpid_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "dual_mode_pid_with_integral_clamp_macros.svh"

module dmpid_err (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  dmpid_pkg::req_type       req_data,
   input  dmpid_pkg::cfg_type       cfg,
   input  logic                     next_ready,
   output logic                     stage_valid,
   output dmpid_pkg::err_stage_type stage_data
);

   logic                     in_valid_ff, in_valid_in;
   dmpid_pkg::req_type       in_data_ff;
   logic                     out_valid_ff, out_valid_in;
   dmpid_pkg::err_stage_type out_data_ff;

   logic signed [dmpid_pkg::DRIVE_INT_WIDTH-1:0] drive_integral_ff;
   logic signed [dmpid_pkg::TURN_INT_WIDTH-1:0]  turn_integral_ff;
   logic signed [dmpid_pkg::ERR_WIDTH-1:0]       drive_last_ff;
   logic signed [dmpid_pkg::ERR_WIDTH-1:0]       turn_last_ff;

   logic                                         out_en, in_en, advance, is_turn;
   logic signed [dmpid_pkg::ERR_WIDTH-1:0]       err;
   logic signed [dmpid_pkg::DRIVE_INT_WIDTH-1:0] integ_sel;
   logic signed [dmpid_pkg::ERR_WIDTH-1:0]       last_sel;
   logic signed [dmpid_pkg::ACC_WIDTH-1:0]       lim_sel, acc_raw;
   logic signed [dmpid_pkg::DRIVE_INT_WIDTH-1:0] acc;
   logic signed [dmpid_pkg::DIFF_WIDTH-1:0]      diff;
   dmpid_pkg::err_stage_type                     stage_in;

   assign out_en    = !out_valid_ff || next_ready;
   assign in_en     = !in_valid_ff || out_en;
   assign advance   = in_valid_ff && out_en;
   assign req_stall = !in_en;

   assign in_valid_in  = in_en ? req_valid : in_valid_ff;
   assign out_valid_in = out_en ? in_valid_ff : out_valid_ff;

   assign is_turn = (in_data_ff.cmd == dmpid_pkg::CMD_TURN);

   always_comb begin
      err = dmpid_pkg::ERR_WIDTH'(in_data_ff.target)
          - dmpid_pkg::ERR_WIDTH'(in_data_ff.measured_value);
      if (is_turn) begin
         integ_sel = dmpid_pkg::DRIVE_INT_WIDTH'(turn_integral_ff);
         last_sel  = turn_last_ff;
         lim_sel   = dmpid_pkg::ACC_WIDTH'($signed({1'b0, cfg.turn_limit}));
      end else begin
         integ_sel = drive_integral_ff;
         last_sel  = drive_last_ff;
         lim_sel   = dmpid_pkg::ACC_WIDTH'($signed({1'b0, cfg.drive_limit}));
      end
      acc_raw = dmpid_pkg::ACC_WIDTH'(integ_sel) + dmpid_pkg::ACC_WIDTH'(err);
      // clamp to +-limit; a zero limit pins the integral at zero
      if (acc_raw >= lim_sel) begin
         acc = dmpid_pkg::DRIVE_INT_WIDTH'(lim_sel);
      end else if (acc_raw <= -lim_sel) begin
         acc = dmpid_pkg::DRIVE_INT_WIDTH'(-lim_sel);
      end else begin
         acc = dmpid_pkg::DRIVE_INT_WIDTH'(acc_raw);
      end
      diff = dmpid_pkg::DIFF_WIDTH'(err) - dmpid_pkg::DIFF_WIDTH'(last_sel);
      stage_in.gains = is_turn ? cfg.turn : cfg.drive;
      stage_in.err   = err;
      stage_in.acc   = acc;
      stage_in.diff  = diff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         drive_integral_ff <= '0;
         turn_integral_ff  <= '0;
         drive_last_ff     <= '0;
         turn_last_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            if (is_turn) begin
               turn_integral_ff <= dmpid_pkg::TURN_INT_WIDTH'(acc);
               turn_last_ff     <= err;
            end else begin
               drive_integral_ff <= acc;
               drive_last_ff     <= err;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_en && req_valid) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= stage_in;
      end
   end

   assign stage_valid = out_valid_ff;
   assign stage_data  = out_data_ff;

   `DMPID_ASSERT_NEXT(a_turn_keeps_drive, clock, reset, advance && is_turn, $stable(drive_integral_ff) && $stable(drive_last_ff))
   `DMPID_ASSERT_NEXT(a_drive_keeps_turn, clock, reset, advance && !is_turn, $stable(turn_integral_ff) && $stable(turn_last_ff))
   `DMPID_ASSERT_NEXT(a_hold_without_advance, clock, reset, !advance, $stable(drive_integral_ff) && $stable(turn_integral_ff))

endmodule

FILE: rtl/core/dmpid_mult.sv
// Multiply stage: the three gain products, registered.
// Depends on dmpid_pkg.
`timescale 1ns / 1ps

module dmpid_mult (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      stage_valid,
   input  dmpid_pkg::err_stage_type  stage_data,
   output logic                      stage_ready,
   input  logic                      next_ready,
   output logic                      prod_valid,
   output dmpid_pkg::prod_stage_type prod_data
);

   logic                      valid_ff, valid_in, en;
   dmpid_pkg::prod_stage_type prod_ff, prod_in;

   assign en          = !valid_ff || next_ready;
   assign stage_ready = en;
   assign valid_in    = en ? stage_valid : valid_ff;

   always_comb begin
      prod_in.p_term = dmpid_pkg::P_WIDTH'(stage_data.gains.kp)
                     * dmpid_pkg::P_WIDTH'(stage_data.err);
      prod_in.i_term = dmpid_pkg::I_WIDTH'(stage_data.gains.ki)
                     * dmpid_pkg::I_WIDTH'(stage_data.acc);
      prod_in.d_term = dmpid_pkg::D_WIDTH'(stage_data.gains.kd)
                     * dmpid_pkg::D_WIDTH'(stage_data.diff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en && stage_valid) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_valid = valid_ff;
   assign prod_data  = prod_ff;

endmodule

FILE: rtl/core/dmpid_out.sv
// Output stage: sum of terms, floor shift, saturation and result register.
// Depends on dmpid_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "dual_mode_pid_with_integral_clamp_macros.svh"

module dmpid_out (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      prod_valid,
   input  dmpid_pkg::prod_stage_type prod_data,
   output logic                      prod_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output dmpid_pkg::rsp_type        rsp_data
);

   logic                                     rsp_valid_ff, rsp_valid_in, en;
   dmpid_pkg::rsp_type                       rsp_ff, rsp_in;
   logic signed [dmpid_pkg::SUM_WIDTH-1:0]   sum;
   logic signed [dmpid_pkg::SHIFT_WIDTH-1:0] scaled;

   assign en           = !rsp_valid_ff || !rsp_stall;
   assign prod_ready   = en;
   assign rsp_valid_in = en ? prod_valid : rsp_valid_ff;

   always_comb begin
      sum = dmpid_pkg::SUM_WIDTH'(prod_data.p_term)
          + dmpid_pkg::SUM_WIDTH'(prod_data.i_term)
          + dmpid_pkg::SUM_WIDTH'(prod_data.d_term);
      // arithmetic shift rounds toward minus infinity
      scaled = dmpid_pkg::SHIFT_WIDTH'(sum >>> dmpid_pkg::GAIN_FRACTION_BITS);
      if (scaled > dmpid_pkg::SHIFT_WIDTH'(dmpid_pkg::POWER_LIMIT)) begin
         rsp_in.drive_power      = dmpid_pkg::POWER_WIDTH'(dmpid_pkg::POWER_LIMIT);
         rsp_in.output_saturated = 1'b1;
      end else if (scaled < -dmpid_pkg::SHIFT_WIDTH'(dmpid_pkg::POWER_LIMIT)) begin
         rsp_in.drive_power      = dmpid_pkg::POWER_WIDTH'(-dmpid_pkg::POWER_LIMIT);
         rsp_in.output_saturated = 1'b1;
      end else begin
         rsp_in.drive_power      = dmpid_pkg::POWER_WIDTH'(scaled);
         rsp_in.output_saturated = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en && prod_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `DMPID_ASSERT_IMPLY(a_power_in_range, clock, reset, rsp_valid_ff, (rsp_ff.drive_power <= 8'sd100) && (rsp_ff.drive_power >= -8'sd100))
   `DMPID_ASSERT_IMPLY(a_sat_at_limit, clock, reset, rsp_valid_ff && rsp_ff.output_saturated, (rsp_ff.drive_power == 8'sd100) || (rsp_ff.drive_power == -8'sd100))
   `DMPID_ASSERT_NEXT(a_free_slot_fills, clock, reset, prod_valid && !rsp_valid_ff, rsp_valid_ff)

endmodule

FILE: rtl/core/dual_mode_pid_with_integral_clamp.sv
// Dual-mode PID controller with clamped integral, top level.
// From an accepted req transaction to rsp_valid, data is registered in the input
// register, error/integral stage, multiply stage and result register, in that order.
// Throughput: one transaction per cycle while rsp_stall is low.
// Synchronous active-high reset empties the pipeline, zeroes loop state and
// restores the gain and windup-limit registers to their defaults.
`timescale 1ns / 1ps

module dual_mode_pid_with_integral_clamp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dmpid_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dmpid_pkg::rsp_type                  rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [dmpid_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [dmpid_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [dmpid_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready
);

   dmpid_pkg::cfg_type        cfg;
   logic                      err_valid, mult_ready, prod_valid, out_ready;
   dmpid_pkg::err_stage_type  err_data;
   dmpid_pkg::prod_stage_type prod_data;

   dmpid_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dmpid_err u_err (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .cfg         (cfg),
      .next_ready  (mult_ready),
      .stage_valid (err_valid),
      .stage_data  (err_data)
   );

   dmpid_mult u_mult (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (err_valid),
      .stage_data  (err_data),
      .stage_ready (mult_ready),
      .next_ready  (out_ready),
      .prod_valid  (prod_valid),
      .prod_data   (prod_data)
   );

   dmpid_out u_out (
      .clock      (clock),
      .reset      (reset),
      .prod_valid (prod_valid),
      .prod_data  (prod_data),
      .prod_ready (out_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: bench/dual_mode_pid_with_integral_clamp_test.sv
// Self-checking bench for the dual-mode PID controller with integral clamp.
// Needs dmpid_pkg and dual_mode_pid_with_integral_clamp; holds its own
// power predictor and scoreboard, APB register writes and stall-driven traffic.
`timescale 1ns / 1ps

module dual_mode_pid_with_integral_clamp_test;
   import dmpid_pkg::*;

   localparam int QUIET_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES = 400;
   localparam int VALUE_MAX = 8388607;
   localparam int VALUE_MIN = -8388608;

   // Expected drive power per accepted transaction, plus a copy of loop state.
   class pid_power_model;
      cfg_type settings;
      logic signed [DRIVE_INT_WIDTH-1:0] drive_integral;
      logic signed [ERR_WIDTH-1:0]       drive_last_err;
      logic signed [TURN_INT_WIDTH-1:0]  turn_integral;
      logic signed [ERR_WIDTH-1:0]       turn_last_err;
      rsp_type expected_power[$];
      int errors;
      int checked;

      function new();
         settings.drive.kp = RESET_KP;
         settings.drive.ki = RESET_KI;
         settings.drive.kd = RESET_KD;
         settings.turn.kp = RESET_KP;
         settings.turn.ki = RESET_KI;
         settings.turn.kd = RESET_KD;
         settings.drive_limit = RESET_DRIVE_LIMIT;
         settings.turn_limit = RESET_TURN_LIMIT;
         drive_integral = '0;
         drive_last_err = '0;
         turn_integral = '0;
         turn_last_err = '0;
         errors = 0;
         checked = 0;
      endfunction

      function void set_register(reg_index_type idx, logic [31:0] word);
         case (idx)
            REG_DRIVE_KP:    settings.drive.kp = word[GAIN_WIDTH-1:0];
            REG_DRIVE_KI:    settings.drive.ki = word[GAIN_WIDTH-1:0];
            REG_DRIVE_KD:    settings.drive.kd = word[GAIN_WIDTH-1:0];
            REG_TURN_KP:     settings.turn.kp = word[GAIN_WIDTH-1:0];
            REG_TURN_KI:     settings.turn.ki = word[GAIN_WIDTH-1:0];
            REG_TURN_KD:     settings.turn.kd = word[GAIN_WIDTH-1:0];
            REG_DRIVE_LIMIT: settings.drive_limit = word[DRIVE_LIMIT_WIDTH-1:0];
            REG_TURN_LIMIT:  settings.turn_limit = word[TURN_LIMIT_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function void record_sample(req_type item);
         longint err, kp, ki, kd, lim, acc, last, total, power;
         rsp_type want;
         err = longint'($signed(item.target)) - longint'($signed(item.measured_value));
         if (item.cmd == CMD_TURN) begin
            kp = settings.turn.kp;
            ki = settings.turn.ki;
            kd = settings.turn.kd;
            lim = settings.turn_limit;
            acc = longint'(turn_integral) + err;
            last = turn_last_err;
         end else begin
            kp = settings.drive.kp;
            ki = settings.drive.ki;
            kd = settings.drive.kd;
            lim = settings.drive_limit;
            acc = longint'(drive_integral) + err;
            last = drive_last_err;
         end
         // clamp lands exactly on the limit; a zero limit pins the integral to zero
         if (acc >= lim) acc = lim;
         else if (acc <= -lim) acc = -lim;
         if (item.cmd == CMD_TURN) begin
            turn_integral = acc[TURN_INT_WIDTH-1:0];
            turn_last_err = err[ERR_WIDTH-1:0];
         end else begin
            drive_integral = acc[DRIVE_INT_WIDTH-1:0];
            drive_last_err = err[ERR_WIDTH-1:0];
         end
         total = kp * err + ki * acc + kd * (err - last);
         power = total >>> GAIN_FRACTION_BITS;   // floor, not truncation
         want.output_saturated = 1'b0;
         if (power > POWER_LIMIT) begin
            power = POWER_LIMIT;
            want.output_saturated = 1'b1;
         end else if (power < -POWER_LIMIT) begin
            power = -POWER_LIMIT;
            want.output_saturated = 1'b1;
         end
         want.drive_power = power[POWER_WIDTH-1:0];
         expected_power.push_back(want);
      endfunction

      function void check_power(rsp_type got);
         rsp_type want;
         if (expected_power.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, power %0d saturated %0b", $time,
                     $signed(got.drive_power), got.output_saturated);
            return;
         end
         want = expected_power.pop_front();
         checked++;
         if (got.drive_power !== want.drive_power) begin
            errors++;
            $display("%0t: drive_power expected %0d, actual %0d", $time,
                     $signed(want.drive_power), $signed(got.drive_power));
         end
         if (got.output_saturated !== want.output_saturated) begin
            errors++;
            $display("%0t: output_saturated expected %0b, actual %0b", $time,
                     want.output_saturated, got.output_saturated);
         end
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic pready;

   pid_power_model model;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int items_sent = 0;
   int settings_loaded = 0;
   cmd_type last_cmd = CMD_DRIVE;

   dual_mode_pid_with_integral_clamp u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: checks each result transaction, stalls at random or for a long hold
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) model.check_power(rsp_data);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("[dual_mode_pid_with_integral_clamp] ERROR");
         $finish;
      end
   end

   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      model.record_sample(item);
      items_sent++;
   endtask

   // sender goes quiet until every result is back, then lets the pipe settle
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (model.expected_power.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // setup then access phase; junk above the register width must be ignored
   task automatic write_register(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] word;
      int width;
      case (idx)
         REG_DRIVE_LIMIT: width = DRIVE_LIMIT_WIDTH;
         REG_TURN_LIMIT:  width = TURN_LIMIT_WIDTH;
         default:         width = GAIN_WIDTH;
      endcase
      word = ($urandom << width) | (value & ((32'd1 << width) - 1));
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      model.set_register(idx, word);
   endtask

   task automatic load_settings(input cfg_type s);
      write_register(REG_DRIVE_KP, 32'(s.drive.kp));
      write_register(REG_DRIVE_KI, 32'(s.drive.ki));
      write_register(REG_DRIVE_KD, 32'(s.drive.kd));
      write_register(REG_TURN_KP, 32'(s.turn.kp));
      write_register(REG_TURN_KI, 32'(s.turn.ki));
      write_register(REG_TURN_KD, 32'(s.turn.kd));
      write_register(REG_DRIVE_LIMIT, 32'(s.drive_limit));
      write_register(REG_TURN_LIMIT, 32'(s.turn_limit));
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      settings_loaded++;
   endtask

   function automatic req_type make_item(cmd_type c, int tgt, int meas);
      req_type r;
      r.cmd = c;
      r.target = tgt[VALUE_WIDTH-1:0];
      r.measured_value = meas[VALUE_WIDTH-1:0];
      return r;
   endfunction

   function automatic logic [GAIN_WIDTH-1:0] random_gain();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return '0;
         3: return 16'($urandom);
         default: return 16'($urandom_range(1023) - 512);
      endcase
   endfunction

   function automatic cfg_type random_settings();
      cfg_type s;
      s.drive.kp = random_gain();
      s.drive.ki = random_gain();
      s.drive.kd = random_gain();
      s.turn.kp = random_gain();
      s.turn.ki = random_gain();
      s.turn.kd = random_gain();
      case ($urandom_range(4))
         0: s.drive_limit = '0;
         1: s.drive_limit = '1;
         2: s.drive_limit = 13'($urandom_range(8191));
         default: s.drive_limit = 13'($urandom_range(300));
      endcase
      case ($urandom_range(4))
         0: s.turn_limit = '0;
         1: s.turn_limit = '1;
         2: s.turn_limit = 9'($urandom_range(511));
         default: s.turn_limit = 9'($urandom_range(100));
      endcase
      return s;
   endfunction

   // mostly runs on one loop with small errors, so integral and derivative build up
   function automatic req_type random_item();
      req_type r;
      int delta;
      if ($urandom_range(4) == 0) last_cmd = cmd_type'($urandom_range(1));
      r.cmd = last_cmd;
      r.target = 24'($urandom);
      case ($urandom_range(9))
         0, 1: r.measured_value = 24'($urandom);
         2: begin
            r.target = $urandom_range(1) ? 24'h7fffff : 24'h800000;
            r.measured_value = $urandom_range(1) ? ~r.target : r.target;
         end
         default: begin
            delta = int'($urandom_range(400)) - 200;
            r.measured_value = 24'(r.target - delta);
         end
      endcase
      return r;
   endfunction

   task automatic run_directed();
      cfg_type s;
      send_idle_pct = 20;
      recv_idle_pct = 20;
      // reset gains: power equals the error, saturation at both edges
      send_item(make_item(CMD_DRIVE, 0, 0));
      send_item(make_item(CMD_DRIVE, 100, 0));
      send_item(make_item(CMD_DRIVE, 101, 0));
      send_item(make_item(CMD_DRIVE, 0, 100));
      send_item(make_item(CMD_DRIVE, 0, 101));
      send_item(make_item(CMD_DRIVE, VALUE_MAX, VALUE_MIN));
      send_item(make_item(CMD_DRIVE, VALUE_MIN, VALUE_MAX));
      send_item(make_item(CMD_TURN, VALUE_MAX, VALUE_MIN));
      send_item(make_item(CMD_TURN, VALUE_MIN, VALUE_MAX));
      send_item(make_item(CMD_TURN, -5, 7));
      drain_pipeline();
      // tiny gain: floor rounding of negative sums
      s = model.settings;
      s.drive.kp = 16'd1;
      load_settings(s);
      send_item(make_item(CMD_DRIVE, 0, 1));
      send_item(make_item(CMD_DRIVE, 255, 0));
      send_item(make_item(CMD_DRIVE, 0, 256));
      send_item(make_item(CMD_DRIVE, 0, 257));
      drain_pipeline();
      // integral alone, small limits: accumulator stops exactly at the limit
      s.drive.kp = '0;
      s.drive.ki = 16'd256;
      s.turn.kp = '0;
      s.turn.ki = 16'd256;
      s.drive_limit = 13'd10;
      s.turn_limit = 9'd5;
      load_settings(s);
      send_item(make_item(CMD_DRIVE, 6, 0));
      send_item(make_item(CMD_DRIVE, 4, 0));
      send_item(make_item(CMD_DRIVE, 5, 0));
      send_item(make_item(CMD_TURN, 100, 0));
      drain_pipeline();
      // zero windup limit with a huge integral gain
      s.drive.ki = 16'h7fff;
      s.turn.ki = 16'h7fff;
      s.drive_limit = '0;
      s.turn_limit = '0;
      load_settings(s);
      send_item(make_item(CMD_DRIVE, 1000, 0));
      send_item(make_item(CMD_DRIVE, 0, 1000));
      send_item(make_item(CMD_TURN, 7, 0));
      drain_pipeline();
      // extreme gains and limits
      s.drive.kp = 16'h8000;
      s.drive.ki = 16'h7fff;
      s.drive.kd = 16'h8000;
      s.turn.kp = 16'h7fff;
      s.turn.ki = 16'h8000;
      s.turn.kd = 16'h7fff;
      s.drive_limit = '1;
      s.turn_limit = '1;
      load_settings(s);
      send_item(make_item(CMD_DRIVE, VALUE_MAX, VALUE_MIN));
      send_item(make_item(CMD_DRIVE, VALUE_MIN, VALUE_MAX));
      send_item(make_item(CMD_TURN, VALUE_MAX, VALUE_MIN));
      send_item(make_item(CMD_TURN, 0, 0));
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input int count,
                            input bit long_hold);
      for (int part = 0; part < 2; part++) begin
         drain_pipeline();
         load_settings(random_settings());
         send_idle_pct = send_pct;
         recv_idle_pct = recv_pct;
         // receiver holds off while the sender keeps pushing: input must back up
         if (long_hold && part == 0) hold_left = HOLD_CYCLES;
         for (int i = 0; i < count / 2; i++) begin
            if (part == 1 && i == count / 4) drain_pipeline();
            send_item(random_item());
         end
      end
   endtask

   initial begin
      model = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_phase(7, 83, 210, 1'b0);
      run_phase(83, 7, 210, 1'b0);
      run_phase(0, 0, 210, 1'b1);
      drain_pipeline();
      if (model.expected_power.size() != 0) begin
         model.errors++;
         $display("%0t: %0d results never arrived", $time, model.expected_power.size());
      end
      $display("Covered %0d transactions on both loops over %0d register settings,",
               items_sent, settings_loaded);
      $display("with both-side stalls, a long receiver hold-off; %0d results checked.",
               model.checked);
      if (model.errors == 0) begin
         $display("[dual_mode_pid_with_integral_clamp] OK");
      end else begin
         $display("[dual_mode_pid_with_integral_clamp] ERROR");
      end
      $finish;
   end

endmodule
